@@ hw/rtl/vcvp_pkg.sv @@
// Shared types and constants for the voxel cell vertex placement block.
// Holds the cube edge table, field widths and the stage-to-stage structs.
// No dependencies.
`timescale 1ns / 1ps

package vcvp_pkg;

  localparam int CORNERS   = 8;
  localparam int EDGES     = 12;
  localparam int AXES      = 3;
  localparam int DENS_W    = 8;
  localparam int CROSS_W   = 8;   // crossing coordinate in 1/254 cell
  localparam int SUM_W     = 12;  // up to twelve crossings of 254
  localparam int COUNT_W   = 4;
  localparam int DEN_W     = 12;  // 254 * count
  localparam int COORD_W   = 17;  // output coordinate field
  localparam int DIV_STEPS = 4;   // quotient bits per divider stage

  localparam logic [CROSS_W-1:0] UNIT = 8'd254;

  typedef logic [DENS_W-1:0]  dens_t;
  typedef logic [CROSS_W-1:0] cross_t;
  typedef logic [SUM_W-1:0]   sum_t;
  typedef logic [COUNT_W-1:0] count_t;
  typedef logic [COORD_W-1:0] coord_t;

  // Corner pairs joined by one cube edge
  localparam logic [2:0] EDGE_LO [EDGES] = '{
    3'd0, 3'd0, 3'd0, 3'd1, 3'd1, 3'd2, 3'd2, 3'd3, 3'd4, 3'd4, 3'd5, 3'd6
  };
  localparam logic [2:0] EDGE_HI [EDGES] = '{
    3'd1, 3'd2, 3'd4, 3'd3, 3'd5, 3'd3, 3'd6, 3'd7, 3'd5, 3'd6, 3'd7, 3'd7
  };

  // Corner index bit for output axis x, y, z
  localparam int AXIS_BIT [AXES] = '{0, 2, 1};

  // Per-edge crossings after the edge stage
  typedef struct packed {
    logic                                  valid;
    logic [EDGES-1:0]                      hit;
    logic [EDGES-1:0][AXES-1:0][CROSS_W-1:0] coord;
  } edge_word_t;

  // Coordinate sums and crossing count after the accumulate stage
  typedef struct packed {
    logic                      valid;
    count_t                    count;
    logic [AXES-1:0][SUM_W-1:0] sum;
  } accum_word_t;

  // Rounded mean coordinates out of the divider
  typedef struct packed {
    logic                        valid;
    count_t                      count;
    logic [AXES-1:0][COORD_W-1:0] vert;
  } result_word_t;

endpackage

@@ hw/rtl/vcvp_edge.sv @@
// Edge stage: finds solid-to-empty cube edges and their crossing points.
// Depends on vcvp_pkg for the edge table and edge_word_t.
`timescale 1ns / 1ps

module vcvp_edge (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       in_valid,
  input  vcvp_pkg::dens_t [vcvp_pkg::CORNERS-1:0]    dens,
  output vcvp_pkg::edge_word_t                       edge_q
);
  import vcvp_pkg::*;

  logic [EDGES-1:0]                        hit;
  logic [EDGES-1:0][AXES-1:0][CROSS_W-1:0] coord;

  // Classify each edge and place its crossing along the three axes
  for (genvar e = 0; e < EDGES; e++) begin : g_edge
    logic       lo_solid;
    logic       hi_solid;
    logic [2:0] solid_c;
    logic [2:0] empty_c;
    dens_t      solid_d;

    assign lo_solid = |dens[EDGE_LO[e]];
    assign hi_solid = |dens[EDGE_HI[e]];
    assign hit[e]   = lo_solid ^ hi_solid;
    assign solid_c  = lo_solid ? EDGE_LO[e] : EDGE_HI[e];
    assign empty_c  = lo_solid ? EDGE_HI[e] : EDGE_LO[e];
    assign solid_d  = lo_solid ? dens[EDGE_LO[e]] : dens[EDGE_HI[e]];

    for (genvar a = 0; a < AXES; a++) begin : g_axis
      logic ps;
      logic pe;
      assign ps = solid_c[AXIS_BIT[a]];
      assign pe = empty_c[AXIS_BIT[a]];
      always_comb begin
        if (!hit[e]) begin
          coord[e][a] = '0;
        end else if (ps == pe) begin
          coord[e][a] = ps ? UNIT : '0;
        end else if (ps) begin
          coord[e][a] = 8'd255 - solid_d;
        end else begin
          coord[e][a] = solid_d - 8'd1;
        end
      end
    end
  end

  // Register the word; only the valid bit is reset
  always_ff @(posedge clk) begin
    if (rst) begin
      edge_q.valid <= 1'b0;
    end else begin
      edge_q.valid <= in_valid;
    end
    edge_q.hit   <= hit;
    edge_q.coord <= coord;
  end

endmodule

@@ hw/rtl/vcvp_accum.sv @@
// Accumulate stage: sums crossing coordinates per axis and counts crossings.
// Depends on vcvp_pkg for edge_word_t and accum_word_t.
`timescale 1ns / 1ps

module vcvp_accum (
  input  logic                    clk,
  input  logic                    rst,
  input  vcvp_pkg::edge_word_t    edge_d,
  output vcvp_pkg::accum_word_t   accum_q
);
  import vcvp_pkg::*;

  logic [5:0][AXES-1:0][8:0]  pair_sum;
  logic [2:0][AXES-1:0][9:0]  quad_sum;
  logic [AXES-1:0][SUM_W-1:0] total;
  count_t                     count;

  // Adder tree: pairs, quads, then the three quads
  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      for (int p = 0; p < 6; p++) begin
        pair_sum[p][a] = {1'b0, edge_d.coord[2*p][a]} + {1'b0, edge_d.coord[2*p+1][a]};
      end
      for (int q = 0; q < 3; q++) begin
        quad_sum[q][a] = {1'b0, pair_sum[2*q][a]} + {1'b0, pair_sum[2*q+1][a]};
      end
      total[a] = {2'b0, quad_sum[0][a]} + {2'b0, quad_sum[1][a]} + {2'b0, quad_sum[2][a]};
    end
  end

  assign count = COUNT_W'($countones(edge_d.hit));

  // Register the word; only the valid bit is reset
  always_ff @(posedge clk) begin
    if (rst) begin
      accum_q.valid <= 1'b0;
    end else begin
      accum_q.valid <= edge_d.valid;
    end
    accum_q.count <= count;
    accum_q.sum   <= total;
  end

endmodule

@@ hw/rtl/vcvp_div.sv @@
// Pipelined restoring divider: mean coordinate = (S*2^F + 127n) / (254n).
// Three lanes share the divisor; DIV_STEPS quotient bits per stage.
// Depends on vcvp_pkg for accum_word_t and result_word_t.
`timescale 1ns / 1ps

module vcvp_div #(
  parameter int FRAC_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  vcvp_pkg::accum_word_t    accum_d,
  output vcvp_pkg::result_word_t   result
);
  import vcvp_pkg::*;

  localparam int QW     = FRAC_BITS + 1;
  localparam int GROUPS = (QW + DIV_STEPS - 1) / DIV_STEPS;
  localparam int NW     = SUM_W + FRAC_BITS;
  localparam int REM_W  = DEN_W + 1;

  typedef logic [REM_W-1:0] rem_t;
  typedef logic [QW-1:0]    quo_t;
  typedef logic [DEN_W-1:0] den_t;

  logic [GROUPS:0] valid_q;
  rem_t            rem_q   [GROUPS+1][AXES];
  quo_t            work_q  [GROUPS+1][AXES];
  den_t            den_q   [GROUPS+1];
  count_t          count_q [GROUPS+1];

  den_t            den_c;
  logic [10:0]     bias_c;
  logic [NW-1:0]   num_c [AXES];

  // Form divisor 254n, rounding bias 127n and the scaled numerators
  always_comb begin
    den_c  = {accum_d.count, 8'b0} - {7'b0, accum_d.count, 1'b0};
    bias_c = {accum_d.count, 7'b0} - {7'b0, accum_d.count};
    for (int a = 0; a < AXES; a++) begin
      num_c[a] = {accum_d.sum[a], {FRAC_BITS{1'b0}}} + NW'(bias_c);
    end
  end

  // Prepare stage: top numerator bits seed the remainder
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q[0] <= 1'b0;
    end else begin
      valid_q[0] <= accum_d.valid;
    end
    den_q[0]   <= den_c;
    count_q[0] <= accum_d.count;
    for (int a = 0; a < AXES; a++) begin
      rem_q[0][a]  <= REM_W'(num_c[a][NW-1:QW]);
      work_q[0][a] <= num_c[a][QW-1:0];
    end
  end

  // Quotient stages: shift in a dividend bit, subtract when it fits
  for (genvar g = 0; g < GROUPS; g++) begin : g_stage
    rem_t r_c [AXES];
    quo_t w_c [AXES];

    always_comb begin
      for (int a = 0; a < AXES; a++) begin
        r_c[a] = rem_q[g][a];
        w_c[a] = work_q[g][a];
        for (int s = 0; s < DIV_STEPS; s++) begin
          if (g * DIV_STEPS + s < QW) begin
            r_c[a] = {r_c[a][REM_W-2:0], w_c[a][QW-1]};
            w_c[a] = {w_c[a][QW-2:0], 1'b0};
            if (r_c[a] >= {1'b0, den_q[g]}) begin
              r_c[a]    = r_c[a] - {1'b0, den_q[g]};
              w_c[a][0] = 1'b1;
            end
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        valid_q[g+1] <= 1'b0;
      end else begin
        valid_q[g+1] <= valid_q[g];
      end
      den_q[g+1]   <= den_q[g];
      count_q[g+1] <= count_q[g];
      rem_q[g+1]   <= r_c;
      work_q[g+1]  <= w_c;
    end
  end

  // Fit the quotient to the output field; no crossings gives the origin
  assign result.valid = valid_q[GROUPS];
  assign result.count = count_q[GROUPS];
  for (genvar a = 0; a < AXES; a++) begin : g_fit
    coord_t fit;
    if (QW >= COORD_W) begin : g_trunc
      assign fit = work_q[GROUPS][a][COORD_W-1:0];
    end else begin : g_ext
      assign fit = COORD_W'(work_q[GROUPS][a]);
    end
    assign result.vert[a] = (count_q[GROUPS] == '0) ? '0 : fit;
  end

endmodule

@@ hw/rtl/voxel_cell_vertex_placement.sv @@
// Top level of the voxel cell vertex placement block.
// Chains vcvp_edge, vcvp_accum and vcvp_div and registers the result word.
// Depends on vcvp_pkg.
//
//   Port group       Direction  Handshake        Contents
//   corner_*_density in         start / busy     eight corner densities
//   vertex_*, count  out        done (strobe)    mean vertex and crossing count
//
// One cell is taken every cycle; busy is high only during reset.
// Each word passes the edge, accumulate and divider set-up registers, then one
// divider stage per four quotient bits, and the output register.
// The divider pipeline sets the latency; each stage resolves four quotient bits.
// Reset (rst, synchronous) clears all valid bits; words in flight are dropped.
// The receiver cannot stall: done is a one-cycle strobe.
`timescale 1ns / 1ps

module voxel_cell_vertex_placement #(
  parameter int FRACTION_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [vcvp_pkg::DENS_W-1:0]  corner_zero_density,
  input  logic [vcvp_pkg::DENS_W-1:0]  corner_one_density,
  input  logic [vcvp_pkg::DENS_W-1:0]  corner_two_density,
  input  logic [vcvp_pkg::DENS_W-1:0]  corner_three_density,
  input  logic [vcvp_pkg::DENS_W-1:0]  corner_four_density,
  input  logic [vcvp_pkg::DENS_W-1:0]  corner_five_density,
  input  logic [vcvp_pkg::DENS_W-1:0]  corner_six_density,
  input  logic [vcvp_pkg::DENS_W-1:0]  corner_seven_density,
  output logic                         done,
  output logic [vcvp_pkg::COORD_W-1:0] vertex_x,
  output logic [vcvp_pkg::COORD_W-1:0] vertex_y,
  output logic [vcvp_pkg::COORD_W-1:0] vertex_z,
  output logic [vcvp_pkg::COUNT_W-1:0] crossing_count
);
  import vcvp_pkg::*;

  localparam int LATENCY = 4 + (FRACTION_BITS + DIV_STEPS) / DIV_STEPS;

  logic                     in_valid;
  dens_t [CORNERS-1:0]      dens;
  edge_word_t               edge_w;
  accum_word_t              accum_w;
  result_word_t             result_w;

  // Accept a word whenever not in reset
  assign busy     = rst;
  assign in_valid = start & ~busy;
  assign dens     = {corner_seven_density, corner_six_density, corner_five_density,
                     corner_four_density, corner_three_density, corner_two_density,
                     corner_one_density, corner_zero_density};

  vcvp_edge u_edge (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .dens     (dens),
    .edge_q   (edge_w)
  );

  vcvp_accum u_accum (
    .clk     (clk),
    .rst     (rst),
    .edge_d  (edge_w),
    .accum_q (accum_w)
  );

  vcvp_div #(
    .FRAC_BITS (FRACTION_BITS)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .accum_d (accum_w),
    .result  (result_w)
  );

  // Output register: strobe for one cycle per word
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= result_w.valid;
    end
    vertex_x       <= result_w.vert[0];
    vertex_y       <= result_w.vert[1];
    vertex_z       <= result_w.vert[2];
    crossing_count <= result_w.count;
  end

  // The crossing count never exceeds EDGES, the edge total of a cube
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (crossing_count <= COUNT_W'(EDGES)))
    else $error("crossing count above edge total");

  // No crossings places the vertex at the origin
  a_empty_origin: assert property (@(posedge clk) disable iff (rst)
    (done && crossing_count == '0) |->
      (vertex_x == '0 && vertex_y == '0 && vertex_z == '0))
    else $error("empty cell gave a non-zero vertex");

  // Every result strobe matches an accepted input word, delayed by the full pipeline depth
  a_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LATENCY))
    else $error("result strobe without matching input word");

endmodule

@@ tb/tb_voxel_cell_vertex_placement.sv @@
// Self-checking testbench for the voxel cell vertex placement block.
// Drives cells through start/busy and checks every done word against a directed expectation or an in-bench predictor.
// Depends on vcvp_pkg and voxel_cell_vertex_placement.
`timescale 1ns / 1ps

module tb_voxel_cell_vertex_placement;

  localparam int FRAC_BITS   = 16;
  localparam int LATENCY     = 4 + (FRAC_BITS + 4) / 4;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASES      = 3;

  typedef logic [7:0][vcvp_pkg::DENS_W-1:0] corners_t;  // byte i is corner i

  typedef struct packed {
    vcvp_pkg::coord_t x;
    vcvp_pkg::coord_t y;
    vcvp_pkg::coord_t z;
    vcvp_pkg::count_t n;
  } vertex_t;

  typedef struct packed {
    corners_t dens;
    bit       typed;   // want holds the expected vertex
    vertex_t  want;
  } row_t;

  // Cube edges as corner pairs; index bit 0 is x, bit 1 is z, bit 2 is y
  localparam logic [2:0] JOIN_A [12] = '{3'd0, 3'd0, 3'd0, 3'd1, 3'd1, 3'd2,
                                         3'd2, 3'd3, 3'd4, 3'd4, 3'd5, 3'd6};
  localparam logic [2:0] JOIN_B [12] = '{3'd1, 3'd2, 3'd4, 3'd3, 3'd5, 3'd3,
                                         3'd6, 3'd7, 3'd5, 3'd6, 3'd7, 3'd7};
  localparam int AXIS_SEL [3] = '{0, 2, 1};

  localparam vertex_t NO_SURFACE = '{17'd0, 17'd0, 17'd0, 4'd0};
  localparam vertex_t AT_ORIGIN  = '{17'd0, 17'd0, 17'd0, 4'd3};
  localparam vertex_t AT_FAR     = '{17'd65536, 17'd65536, 17'd65536, 4'd3};

  localparam int DIRECTED_ROWS = 19;
  localparam row_t DIRECTED [DIRECTED_ROWS] = '{
    '{64'h00000000_00000000, 1'b1, NO_SURFACE},  // all empty
    '{64'hFFFFFFFF_FFFFFFFF, 1'b1, NO_SURFACE},  // all solid, densest
    '{64'h01010101_01010101, 1'b1, NO_SURFACE},  // all solid, thinnest
    '{64'h00000000_00000001, 1'b1, AT_ORIGIN},   // density one sits on corner 0
    '{64'h01000000_00000000, 1'b1, AT_FAR},      // density one sits on corner 7
    '{64'hFFFFFFFF_FFFFFF00, 1'b1, AT_ORIGIN},   // only corner 0 empty
    '{64'h00FFFFFF_FFFFFFFF, 1'b1, AT_FAR},      // only corner 7 empty
    '{64'h00000000_000000FF, 1'b0, NO_SURFACE},
    '{64'hFF000000_00000000, 1'b0, NO_SURFACE},
    '{64'h00FFFF00_FF0000FF, 1'b0, NO_SURFACE},  // checkerboard, twelve crossings
    '{64'hFF0000FF_00FFFF00, 1'b0, NO_SURFACE},  // inverse checkerboard
    '{64'h00010100_01000001, 1'b0, NO_SURFACE},
    '{64'h7F800102_40C02010, 1'b0, NO_SURFACE},
    '{64'h00A5005A_00003C00, 1'b0, NO_SURFACE},
    '{64'hAA55AA55_00000000, 1'b0, NO_SURFACE},
    '{64'h00000000_55AA55AA, 1'b0, NO_SURFACE},
    '{64'h00000000_00008080, 1'b0, NO_SURFACE},
    '{64'hFEFEFEFE_00000000, 1'b0, NO_SURFACE},  // top face solid
    '{64'h00000000_02020202, 1'b0, NO_SURFACE}   // bottom face solid
  };

  localparam int PHASE_IDLE  [PHASES] = '{31, 70, 0};
  localparam int PHASE_CELLS [PHASES] = '{420, 420, 410};

  logic     clk;
  logic     rst;
  logic     start;
  logic     busy;
  logic     done;
  corners_t cell_in;
  vcvp_pkg::coord_t vertex_x, vertex_y, vertex_z;
  vcvp_pkg::count_t crossing_count;

  vertex_t pending_vertices [$];
  int      sender_idle_pct;
  int      cells_sent;
  int      vertices_checked;
  int      surface_cells;
  int      failures;
  int      cycles;

  voxel_cell_vertex_placement #(.FRACTION_BITS(FRAC_BITS)) dut (
    .clk                  (clk),
    .rst                  (rst),
    .start                (start),
    .busy                 (busy),
    .corner_zero_density  (cell_in[0]),
    .corner_one_density   (cell_in[1]),
    .corner_two_density   (cell_in[2]),
    .corner_three_density (cell_in[3]),
    .corner_four_density  (cell_in[4]),
    .corner_five_density  (cell_in[5]),
    .corner_six_density   (cell_in[6]),
    .corner_seven_density (cell_in[7]),
    .done                 (done),
    .vertex_x             (vertex_x),
    .vertex_y             (vertex_y),
    .vertex_z             (vertex_z),
    .crossing_count       (crossing_count)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Mean of the edge crossings, summed in units of 1/254 cell, rounded to unsigned Q1.16 cell units
  function automatic vertex_t place_vertex(input corners_t c);
    longint unsigned sum [3];
    longint unsigned q;
    vcvp_pkg::coord_t co [3];
    logic [2:0] solid_c, empty_c;
    int n;
    int d;
    bit found;
    bit ps, pe;
    vertex_t v;
    n = 0;
    for (int a = 0; a < 3; a++) sum[a] = 0;
    for (int e = 0; e < 12; e++) begin
      found = 1'b1;
      if (c[JOIN_A[e]] != 0 && c[JOIN_B[e]] == 0) begin
        solid_c = JOIN_A[e];
        empty_c = JOIN_B[e];
      end else if (c[JOIN_B[e]] != 0 && c[JOIN_A[e]] == 0) begin
        solid_c = JOIN_B[e];
        empty_c = JOIN_A[e];
      end else begin
        found = 1'b0;
      end
      if (found) begin
        d = int'(c[solid_c]);
        for (int a = 0; a < 3; a++) begin
          ps = solid_c[AXIS_SEL[a]];
          pe = empty_c[AXIS_SEL[a]];
          if (ps == pe) sum[a] += ps ? 64'd254 : 64'd0;
          else sum[a] += 64'(ps ? (255 - d) : (d - 1));
        end
        n++;
      end
    end
    // Round to nearest, ties up
    for (int a = 0; a < 3; a++) begin
      q = 0;
      if (n != 0) q = ((sum[a] << FRAC_BITS) + 127 * n) / (254 * n);
      co[a] = q[16:0];
    end
    v.x = co[0];
    v.y = co[1];
    v.z = co[2];
    v.n = n[3:0];
    return v;
  endfunction

  function automatic int field_differs(input string name, input int unsigned want,
                                       input int unsigned got);
    if (want == got) return 0;
    $display("%0t: %s expected %0d got %0d", $time, name, want, got);
    return 1;
  endfunction

  // Offer one cell, idling at random first; record the expected vertex on acceptance
  task automatic send_cell(input corners_t c, input bit typed, input vertex_t want);
    bit taken;
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    cell_in <= c;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk);
      taken = !busy;
    end
    pending_vertices = {pending_vertices, (typed ? want : place_vertex(c))};
    cells_sent++;
  endtask

  // Hold the sender off until every expected word has come back
  task automatic wait_for_results();
    while (pending_vertices.size() != 0) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Check each done word against the oldest expectation
  always @(posedge clk) begin
    vertex_t exp_v;
    if (!rst && done) begin
      if (pending_vertices.size() == 0) begin
        $display("%0t: vertex word with nothing expected: x %0d y %0d z %0d count %0d",
                 $time, vertex_x, vertex_y, vertex_z, crossing_count);
        failures++;
      end else begin
        exp_v = pending_vertices.pop_front();
        failures += field_differs("vertex_x", 32'(exp_v.x), 32'(vertex_x));
        failures += field_differs("vertex_y", 32'(exp_v.y), 32'(vertex_y));
        failures += field_differs("vertex_z", 32'(exp_v.z), 32'(vertex_z));
        failures += field_differs("crossing_count", 32'(exp_v.n), 32'(crossing_count));
        vertices_checked++;
        if (crossing_count != 0) surface_cells++;
      end
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d vertices outstanding", $time, pending_vertices.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    corners_t c;
    int pick;
    rst     <= 1'b1;
    start   <= 1'b0;
    cell_in <= '0;
    sender_idle_pct = 0;
    cells_sent = 0;
    vertices_checked = 0;
    surface_cells = 0;
    failures = 0;
    cycles = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed cells, back to back
    for (int r = 0; r < DIRECTED_ROWS; r++)
      send_cell(DIRECTED[r].dens, DIRECTED[r].typed, DIRECTED[r].want);
    wait_for_results();

    // Random cells: mostly mixed solid and empty corners, some uniform noise
    for (int ph = 0; ph < PHASES; ph++) begin
      sender_idle_pct = PHASE_IDLE[ph];
      repeat (PHASE_CELLS[ph]) begin
        if ($urandom_range(0, 15) == 0) begin
          c = {$urandom, $urandom};
        end else begin
          for (int i = 0; i < 8; i++) begin
            pick = $urandom_range(0, 9);
            if (pick < 4) c[i] = 8'd0;
            else if (pick == 4) c[i] = 8'd1;
            else if (pick == 5) c[i] = 8'd255;
            else c[i] = 8'($urandom_range(1, 255));
          end
        end
        send_cell(c, 1'b0, NO_SURFACE);
      end
      wait_for_results();
    end

    // Drain, then let any stray word show up
    repeat (LATENCY + 4) @(posedge clk);
    $display("%0d cells sent, %0d vertices checked, %0d of them with surface crossings",
             cells_sent, vertices_checked, surface_cells);
    $display("covered empty, solid, density-one and twelve-crossing cells at three gap rates");
    if (failures == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
